### sv/dfdd_pkg.sv
package dfdd_pkg;

    // Largest frame the store can hold, in pixels.
    localparam int MAX_PIXELS = 262144;

    localparam int INDEX_W = 18;
    localparam int BYTE_W = 8;
    localparam int COUNT_W = 19;
    localparam int LEN_W = 24;

    // Configuration register indexes.
    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_PIXEL_COUNT = 1'b1;

    localparam logic MODE_RESET = 1'b1;
    localparam logic [COUNT_W-1:0] PIXEL_COUNT_RESET = 19'd262144;

    // Delta packet framing.
    localparam logic [1:0] HEADER_BYTES = 2'd3;
    localparam logic [1:0] REC_LAST_BYTE = 2'd3;
    localparam logic [BYTE_W-1:0] HI_BITS_MASK = 8'h03;
    localparam int SUB_BIT = 7;

    typedef logic [1:0] op_kind_t;
    localparam op_kind_t OP_RAW = 2'd0;   // raw pixel write
    localparam op_kind_t OP_DELTA = 2'd1; // delta record, read-modify-write
    localparam op_kind_t OP_READ = 2'd2;  // read-back request
    localparam op_kind_t OP_MARK = 2'd3;  // end of packet with no pixel

    typedef struct packed {
        op_kind_t kind;
        logic [INDEX_W-1:0] index;
        logic [BYTE_W-1:0] data;
        logic sub;
        logic err;
        logic eof;
    } op_t;

endpackage

### sv/dfdd_parser.sv
module dfdd_parser #(
    parameter int MAX_PIXELS = dfdd_pkg::MAX_PIXELS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic                            cfg_index,
    input  logic [dfdd_pkg::COUNT_W-1:0]    cfg_data,
    input  logic                            in_fire,
    input  logic                            req_type,
    input  logic [dfdd_pkg::BYTE_W-1:0]     rx_byte,
    input  logic [dfdd_pkg::INDEX_W-1:0]    read_index,
    output logic                            op_valid,
    output dfdd_pkg::op_t                   op
);

    localparam logic [dfdd_pkg::COUNT_W-1:0] MAX_COUNT = dfdd_pkg::COUNT_W'(MAX_PIXELS);

    logic                             mode_reg;
    logic [dfdd_pkg::COUNT_W-1:0]     pixel_count_reg;

    logic                             first_frame_pending_reg, first_frame_pending_next;
    logic [dfdd_pkg::INDEX_W-1:0]     raw_position_reg, raw_position_next;
    logic [1:0]                       header_byte_count_reg, header_byte_count_next;
    logic [dfdd_pkg::LEN_W-1:0]       packet_bytes_left_reg, packet_bytes_left_next;
    logic [1:0]                       record_byte_position_reg, record_byte_position_next;
    logic [dfdd_pkg::INDEX_W-1:0]     partial_index_reg, partial_index_next;
    logic                             subtract_flag_reg, subtract_flag_next;

    logic [dfdd_pkg::COUNT_W-1:0]     count;
    logic [dfdd_pkg::COUNT_W-1:0]     count_m1;
    logic                             raw_last;
    logic [dfdd_pkg::LEN_W-1:0]       len_acc;
    logic [dfdd_pkg::LEN_W-1:0]       len_dec;
    logic                             body_ends;
    logic [1:0]                       rec_hi_bits;

    // A pixel count of zero acts as one; anything past the store acts as full size.
    always_comb
    begin
        if (pixel_count_reg == '0)
        begin
            count = dfdd_pkg::COUNT_W'(1);
        end
        else if (pixel_count_reg > MAX_COUNT)
        begin
            count = MAX_COUNT;
        end
        else
        begin
            count = pixel_count_reg;
        end
    end

    assign count_m1 = count - dfdd_pkg::COUNT_W'(1);
    assign raw_last = ({1'b0, raw_position_reg} >= count_m1);
    assign len_dec = packet_bytes_left_reg - dfdd_pkg::LEN_W'(1);
    assign body_ends = (len_dec == '0);
    assign rec_hi_bits = 2'(rx_byte & dfdd_pkg::HI_BITS_MASK);

    always_comb
    begin
        case (header_byte_count_reg)
            2'd0:    len_acc = {16'd0, rx_byte};
            2'd1:    len_acc = packet_bytes_left_reg | {8'd0, rx_byte, 8'd0};
            default: len_acc = packet_bytes_left_reg | {rx_byte, 16'd0};
        endcase
    end

    always_comb
    begin
        first_frame_pending_next = first_frame_pending_reg;
        raw_position_next = raw_position_reg;
        header_byte_count_next = header_byte_count_reg;
        packet_bytes_left_next = packet_bytes_left_reg;
        record_byte_position_next = record_byte_position_reg;
        partial_index_next = partial_index_reg;
        subtract_flag_next = subtract_flag_reg;

        op_valid = 1'b0;
        op.kind = dfdd_pkg::OP_MARK;
        op.index = '0;
        op.data = rx_byte;
        op.sub = subtract_flag_reg;
        op.err = 1'b0;
        op.eof = 1'b0;

        if (req_type)
        begin
            op_valid = 1'b1;
            op.kind = dfdd_pkg::OP_READ;
            op.index = read_index;
            op.err = ({1'b0, read_index} >= count);
        end
        else if (!mode_reg || first_frame_pending_reg)
        begin
            op_valid = 1'b1;
            op.kind = dfdd_pkg::OP_RAW;
            op.index = raw_position_reg;
            op.eof = raw_last;
            if (raw_last)
            begin
                raw_position_next = '0;
                first_frame_pending_next = 1'b0;
            end
            else
            begin
                raw_position_next = raw_position_reg + dfdd_pkg::INDEX_W'(1);
            end
        end
        else if (header_byte_count_reg != dfdd_pkg::HEADER_BYTES)
        begin
            packet_bytes_left_next = len_acc;
            header_byte_count_next = header_byte_count_reg + 2'd1;
            if (header_byte_count_next == dfdd_pkg::HEADER_BYTES)
            begin
                record_byte_position_next = '0;
                if (len_acc == '0)
                begin
                    // Empty packet: report the end of frame right away.
                    header_byte_count_next = '0;
                    op_valid = 1'b1;
                    op.eof = 1'b1;
                end
            end
        end
        else
        begin
            packet_bytes_left_next = len_dec;
            record_byte_position_next = record_byte_position_reg + 2'd1;
            if (body_ends)
            begin
                header_byte_count_next = '0;
            end
            case (record_byte_position_reg)
                2'd0:
                begin
                    partial_index_next = {10'd0, rx_byte};
                end
                2'd1:
                begin
                    partial_index_next = {2'b00, rx_byte, partial_index_reg[7:0]};
                end
                2'd2:
                begin
                    partial_index_next = {rec_hi_bits, partial_index_reg[15:0]};
                    subtract_flag_next = rx_byte[dfdd_pkg::SUB_BIT];
                end
                default:
                begin
                    // Last record byte carries the delta.
                    op_valid = 1'b1;
                    op.kind = dfdd_pkg::OP_DELTA;
                    op.index = partial_index_reg;
                    op.err = ({1'b0, partial_index_reg} >= count);
                    op.eof = body_ends;
                end
            endcase
            if (body_ends && record_byte_position_reg != dfdd_pkg::REC_LAST_BYTE)
            begin
                // Packet ended inside a record: the record is dropped.
                op_valid = 1'b1;
                op.eof = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= dfdd_pkg::MODE_RESET;
            pixel_count_reg <= dfdd_pkg::PIXEL_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                dfdd_pkg::CFG_MODE:        mode_reg <= cfg_data[0];
                dfdd_pkg::CFG_PIXEL_COUNT: pixel_count_reg <= cfg_data;
                default:                   mode_reg <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_frame_pending_reg <= 1'b1;
            raw_position_reg <= '0;
            header_byte_count_reg <= '0;
            packet_bytes_left_reg <= '0;
            record_byte_position_reg <= '0;
            partial_index_reg <= '0;
            subtract_flag_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            first_frame_pending_reg <= first_frame_pending_next;
            raw_position_reg <= raw_position_next;
            header_byte_count_reg <= header_byte_count_next;
            packet_bytes_left_reg <= packet_bytes_left_next;
            record_byte_position_reg <= record_byte_position_next;
            partial_index_reg <= partial_index_next;
            subtract_flag_reg <= subtract_flag_next;
        end
    end

endmodule

### sv/dfdd_store.sv
module dfdd_store #(
    parameter int MAX_PIXELS = dfdd_pkg::MAX_PIXELS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rd_en,
    input  logic [dfdd_pkg::INDEX_W-1:0]    rd_addr,
    input  logic                            wr_en,
    input  logic [dfdd_pkg::INDEX_W-1:0]    wr_addr,
    input  logic [dfdd_pkg::BYTE_W-1:0]     wr_data,
    output logic [dfdd_pkg::BYTE_W-1:0]     rd_data
);

    localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    logic [dfdd_pkg::BYTE_W-1:0] mem [0:MAX_PIXELS-1];
    logic [dfdd_pkg::BYTE_W-1:0] rdata_reg;
    logic [dfdd_pkg::BYTE_W-1:0] fwd_data_reg;
    logic                        fwd_hit_reg;

    // Read returns the old contents when the same entry is written in that
    // cycle, so the written value is kept aside and chosen instead.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr[ADDR_W-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr[ADDR_W-1:0]];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rdata_reg;

endmodule

### sv/depth_frame_delta_decoder.sv
// Depth frame delta decoder: takes the received byte stream of a depth-camera
// link, one request per cycle while results are taken, and maintains an 8-bit
// frame store of up to MAX_PIXELS pixels. The first frame (and every frame
// when mode is 0) is raw, one byte per pixel; afterwards, in mode 1, frames
// are delta packets made of a 3-byte little-endian length and 4-byte records
// (18-bit index, subtract flag in bit 7 of the third byte, delta byte). Every
// pixel write, every read-back request and every packet end produces one
// result; length bytes and the first three bytes of a record produce none
// unless the packet ends there. The block sustains one request per clock while
// results are taken: a request is parsed and its store read issued as it is
// accepted; request and read data are registered, and as it moves on the delta
// is added, the store written and the result registered. A same-pixel write
// during a read is forwarded around the store. The store is not cleared at
// reset; a pixel must be written by a raw frame before a delta or read-back
// touches it. Configuration writes are taken at any time and must only be
// issued while no request is in flight.
module depth_frame_delta_decoder #(
    parameter int MAX_PIXELS = dfdd_pkg::MAX_PIXELS
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: index 0 is mode, index 1 is pixel_count.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [18:0] cfg_data,
    // Requests.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [7:0] rx_byte, [25:8] read_index, rest zero
    input  logic        s_axis_tuser,   // [0] req_type
    // Results.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [17:0] pixel_index, [25:18] pixel_value,
                                        // [26] pixel_valid, [27] index_error, rest zero
    output logic        m_axis_tlast,   // end_of_frame
    output logic        m_axis_tuser    // [0] is_read_reply
);

    logic                           in_fire;
    logic                           op_valid;
    dfdd_pkg::op_t                  op;

    // Stage holding a parsed request while the store read completes.
    logic                           s1_valid_reg;
    dfdd_pkg::op_t                  s1_reg;
    logic                           s1_move;

    logic [dfdd_pkg::BYTE_W-1:0]    base;
    logic [dfdd_pkg::BYTE_W-1:0]    new_value;
    logic                           new_valid;
    logic                           wr_en;

    // Result register.
    logic                           out_valid_reg;
    logic [dfdd_pkg::INDEX_W-1:0]   out_index_reg;
    logic [dfdd_pkg::BYTE_W-1:0]    out_value_reg;
    logic                           out_pixel_valid_reg;
    logic                           out_err_reg;
    logic                           out_eof_reg;
    logic                           out_read_reg;

    assign cfg_ready = 1'b1;

    // The parsing stage advances whenever its content can move to the result
    // register; a request is accepted when the stage is empty or moving on.
    assign s1_move = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_move;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    dfdd_parser #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_fire    (in_fire),
        .req_type   (s_axis_tuser),
        .rx_byte    (s_axis_tdata[7:0]),
        .read_index (s_axis_tdata[25:8]),
        .op_valid   (op_valid),
        .op         (op)
    );

    // Store writes happen as a result leaves the parsing stage; raw pixels and
    // in-range delta records update the frame.
    assign wr_en = s1_move && ((s1_reg.kind == dfdd_pkg::OP_RAW) ||
                               (s1_reg.kind == dfdd_pkg::OP_DELTA && !s1_reg.err));

    dfdd_store #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire && op_valid),
        .rd_addr (op.index),
        .wr_en   (wr_en),
        .wr_addr (s1_reg.index),
        .wr_data (new_value),
        .rd_data (base)
    );

    always_comb
    begin
        new_value = '0;
        new_valid = 1'b0;
        case (s1_reg.kind)
            dfdd_pkg::OP_RAW:
            begin
                new_value = s1_reg.data;
                new_valid = 1'b1;
            end
            dfdd_pkg::OP_DELTA:
            begin
                if (!s1_reg.err)
                begin
                    new_value = s1_reg.sub ? (base - s1_reg.data) : (base + s1_reg.data);
                    new_valid = 1'b1;
                end
            end
            dfdd_pkg::OP_READ:
            begin
                if (!s1_reg.err)
                begin
                    new_value = base;
                    new_valid = 1'b1;
                end
            end
            default:
            begin
                new_value = '0;
                new_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                s1_valid_reg <= in_fire && op_valid;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && op_valid)
        begin
            s1_reg <= op;
        end
        if (s1_move)
        begin
            out_index_reg <= s1_reg.index;
            out_value_reg <= new_value;
            out_pixel_valid_reg <= new_valid;
            out_err_reg <= s1_reg.err;
            out_eof_reg <= s1_reg.eof;
            out_read_reg <= (s1_reg.kind == dfdd_pkg::OP_READ);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {4'd0, out_err_reg, out_pixel_valid_reg, out_value_reg, out_index_reg};
    assign m_axis_tlast = out_eof_reg;
    assign m_axis_tuser = out_read_reg;

endmodule

### sv/dfdd_checker.sv
module dfdd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // Read replies never close a frame.
    a_read_no_eof: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> !m_axis_tlast)
        else $error("read reply marked end of frame");

    // A pixel is never both valid and out of range.
    a_valid_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[26] && m_axis_tdata[27]))
        else $error("pixel both valid and in error");

    // A result with no pixel and no error is a bare end-of-packet marker.
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[26] && !m_axis_tdata[27] |->
            m_axis_tlast && !m_axis_tuser && (m_axis_tdata[25:0] == 26'd0))
        else $error("malformed end-of-packet marker");

    // Out-of-range results carry a zero value.
    a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[27] |-> (m_axis_tdata[25:18] == 8'd0))
        else $error("index error with nonzero value");

endmodule

bind depth_frame_delta_decoder dfdd_checker u_dfdd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
